[src/spnkr_pkg.sv]
// shared types, constants and substitution/permutation functions for the key recovery pipeline
package spnkr_pkg;

   localparam int unsigned BlockWidth  = 16;
   localparam int unsigned NibbleWidth = 4;
   localparam int unsigned NibbleCount = BlockWidth / NibbleWidth;
   localparam int unsigned CsrIndexWidth = 3;

   localparam logic [CsrIndexWidth-1:0] CsrKeyFive  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrKeyFour  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrKeyThree = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrKeyTwo   = 3'd3;

   localparam logic [BlockWidth-1:0] KeyFiveReset  = 16'h5d8e;
   localparam logic [BlockWidth-1:0] KeyFourReset  = 16'hd6bf;
   localparam logic [BlockWidth-1:0] KeyThreeReset = 16'h7c76;
   localparam logic [BlockWidth-1:0] KeyTwoReset   = 16'h14dc;

   typedef logic [BlockWidth-1:0] block_type;

   typedef struct packed {
      block_type plain;
      block_type state;
   } word_type;

   localparam logic [NibbleWidth-1:0] InvSbox [16] = '{
      4'he, 4'h3, 4'h4, 4'h8, 4'h1, 4'hc, 4'ha, 4'hf,
      4'h7, 4'hd, 4'h9, 4'h6, 4'hb, 4'h2, 4'h0, 4'h5
   };

   localparam logic [NibbleWidth-1:0] PermTab [16] = '{
      4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
      4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15
   };

   function automatic block_type inv_substitute(input block_type v);
      block_type r;
      r = '0;
      for (int n = 0; n < NibbleCount; n++) begin
         r[n*NibbleWidth +: NibbleWidth] = InvSbox[v[n*NibbleWidth +: NibbleWidth]];
      end
      return r;
   endfunction

   function automatic block_type inv_permute(input block_type v);
      block_type r;
      r = '0;
      for (int i = 0; i < BlockWidth; i++) begin
         r[PermTab[i]] = v[i];
      end
      return r;
   endfunction

endpackage

[src/spnkr_round.sv]
// one pipeline stage: key xor, optional inverse permutation and inverse substitution
module spnkr_round (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 perm_en,
   input  spnkr_pkg::block_type round_key,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  spnkr_pkg::word_type  in_word,
   output logic                 out_valid,
   input  logic                 out_ready,
   output spnkr_pkg::word_type  out_word
);

   logic                valid_ff;
   logic                valid_in;
   spnkr_pkg::word_type word_ff;
   spnkr_pkg::word_type word_in;
   spnkr_pkg::block_type mixed;
   spnkr_pkg::block_type routed;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      mixed  = in_word.state ^ round_key;
      routed = perm_en ? spnkr_pkg::inv_permute(mixed) : mixed;
      word_in.plain = in_word.plain;
      word_in.state = spnkr_pkg::inv_substitute(routed);
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> out_valid)
      else $error("accepted word did not reach stage register");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(word_ff))
      else $error("stalled stage word changed");

   a_drain_empties : assert property (@(posedge clock) disable iff (reset)
      out_valid && out_ready && !in_valid |=> !out_valid)
      else $error("stage kept a word that was already taken");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !out_valid)
      else $error("stage valid after reset");

endmodule

[src/spn_first_round_key_recovery.sv]
// top level: round key registers and four-stage inverse network pipeline
//
//  channel | direction | ports                                  | handshake
//  req     | in        | req_plain_block, req_cipher_block      | req_valid / req_ready
//  rsp     | out       | rsp_first_key                          | rsp_valid / rsp_ready
//  csr     | in        | csr_index, csr_write_data              | csr_write_enable
//
//  four register stages, one per inverse round; one word per cycle while rsp_ready stays high
//  each stage holds its word while the next stage is full and stalled
//  reset clears all valid bits and loads the default round keys
module spn_first_round_key_recovery (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [spnkr_pkg::BlockWidth-1:0]     req_plain_block,
   input  logic [spnkr_pkg::BlockWidth-1:0]     req_cipher_block,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [spnkr_pkg::BlockWidth-1:0]     rsp_first_key,
   input  logic                                 csr_write_enable,
   input  logic [spnkr_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [spnkr_pkg::BlockWidth-1:0]     csr_write_data
);

   localparam int unsigned StageCount = 4;

   spnkr_pkg::block_type key_ff [StageCount];
   spnkr_pkg::block_type key_in [StageCount];

   logic                stage_valid [StageCount+1];
   logic                stage_ready [StageCount+1];
   spnkr_pkg::word_type stage_word  [StageCount+1];

   always_comb begin
      for (int s = 0; s < StageCount; s++) begin
         key_in[s] = key_ff[s];
      end
      if (csr_write_enable) begin
         unique case (csr_index)
            spnkr_pkg::CsrKeyFive:  key_in[0] = csr_write_data;
            spnkr_pkg::CsrKeyFour:  key_in[1] = csr_write_data;
            spnkr_pkg::CsrKeyThree: key_in[2] = csr_write_data;
            spnkr_pkg::CsrKeyTwo:   key_in[3] = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= spnkr_pkg::KeyFiveReset;
         key_ff[1] <= spnkr_pkg::KeyFourReset;
         key_ff[2] <= spnkr_pkg::KeyThreeReset;
         key_ff[3] <= spnkr_pkg::KeyTwoReset;
      end else begin
         for (int s = 0; s < StageCount; s++) begin
            key_ff[s] <= key_in[s];
         end
      end
   end

   assign stage_valid[0]       = req_valid;
   assign req_ready            = stage_ready[0];
   assign stage_word[0].plain  = req_plain_block;
   assign stage_word[0].state  = req_cipher_block;

   for (genvar s = 0; s < StageCount; s++) begin : g_round
      spnkr_round u_round (
         .clock     (clock),
         .reset     (reset),
         .perm_en   (s != 0),
         .round_key (key_ff[s]),
         .in_valid  (stage_valid[s]),
         .in_ready  (stage_ready[s]),
         .in_word   (stage_word[s]),
         .out_valid (stage_valid[s+1]),
         .out_ready (stage_ready[s+1]),
         .out_word  (stage_word[s+1])
      );
   end

   assign rsp_valid              = stage_valid[StageCount];
   assign stage_ready[StageCount] = rsp_ready;
   assign rsp_first_key = stage_word[StageCount].plain ^ stage_word[StageCount].state;

endmodule
